/* src/acsq_pkg.sv */
// Shared widths, codes and the queue word for the calibration sequencer.
package acsq_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int NUM_ADCS_DEF  = 3;
    localparam int COUNT_BITS_DEF = 16;
    localparam int REQ_BITS      = 16;
    localparam int NUM_CHANS     = 8;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GROUND_ONE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RESIDUAL_ONE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GROUND_TWO   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_SCALE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REQUIRED_ROUNDS  = 3'd4;

    localparam logic       CMD_STEP   = 1'b0;
    localparam logic       CMD_SAMPLE = 1'b1;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    localparam logic [1:0] GAIN_NONE = 2'd0;
    localparam logic [1:0] GAIN_ONE  = 2'd1;
    localparam logic [1:0] GAIN_TWO  = 2'd2;

    typedef struct packed {
        logic                          command;
        logic [1:0]                    adc;
        logic signed [SAMPLE_BITS-1:0] ground;
        logic signed [SAMPLE_BITS-1:0] supply;
        logic signed [SAMPLE_BITS-1:0] mid;
        logic [SAMPLE_BITS+1:0]        res_mag;
    } acsq_item_t;

endpackage

/* src/acsq_front.sv */
// Front end: accepts a word, forms ground, supply, mid and residual magnitude.
module acsq_front (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [acsq_pkg::NUM_CHANS*acsq_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  logic [2:0]                                      s_tuser,
    output logic                                            push,
    output acsq_pkg::acsq_item_t                            push_item,
    input  logic                                            full
);
    import acsq_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = SB + 2;
    localparam int SH  = SB + 3;
    localparam logic [SW-1:0] RECIP3 = SW'(((64'd1 << SH) + 64'd2) / 64'd3);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  cmd_reg;
    logic [1:0]            adc_reg;
    logic signed [SW-1:0]  gsum_reg;
    logic [SW-1:0]         sabs_reg;
    logic                  sneg_reg;
    logic signed [SB-1:0]  mid_reg;
    logic [2*SW-1:0]       prod_reg;
    logic signed [SB-1:0]  ground_reg;

    logic signed [SW-1:0]  gsum, ssum;
    logic signed [SW-1:0]  gadj;
    logic [SB-1:0]         quot;
    logic signed [SB-1:0]  supply;
    logic signed [SB:0]    diff_pm, diff_lm, half_pm;
    logic signed [SB+1:0]  resid;

    function automatic logic signed [SW-1:0] ch(input int i,
        input logic [NUM_CHANS*SB-1:0] d);
        ch = SW'($signed(d[i*SB +: SB]));
    endfunction

    assign s_tready = (state_reg == F_IDLE);

    always_comb
    begin
        gsum = ch(1, s_tdata) + ch(3, s_tdata) + ch(5, s_tdata) + ch(7, s_tdata);
        ssum = ch(0, s_tdata) + ch(2, s_tdata) + ch(6, s_tdata);
        gadj = gsum_reg + (gsum_reg[SW-1] ? SW'(3) : SW'(0));
    end

    always_comb
    begin
        quot    = prod_reg[SH +: SB];
        supply  = sneg_reg ? -$signed(quot) : $signed(quot);
        diff_pm = (SB+1)'(supply) - (SB+1)'(ground_reg);
        half_pm = (diff_pm + (diff_pm[SB] ? (SB+1)'(1) : (SB+1)'(0))) >>> 1;
        diff_lm = (SB+1)'(mid_reg) - (SB+1)'(ground_reg);
        resid   = (SB+2)'(half_pm) - (SB+2)'(diff_lm);
        push_item.command = cmd_reg;
        push_item.adc     = adc_reg;
        push_item.ground  = ground_reg;
        push_item.supply  = supply;
        push_item.mid     = mid_reg;
        push_item.res_mag = resid[SB+1] ? (SB+2)'(-resid) : (SB+2)'(resid);
    end

    assign push = (state_reg == F_FIN) && !full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_FIN;
            end
            F_FIN:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser[0];
            adc_reg  <= s_tuser[2:1];
            gsum_reg <= gsum;
            sneg_reg <= ssum[SW-1];
            sabs_reg <= ssum[SW-1] ? SW'(-ssum) : SW'(ssum);
            mid_reg  <= $signed(s_tdata[4*SB +: SB]);
        end
        if (state_reg == F_MUL)
        begin
            prod_reg   <= sabs_reg * RECIP3;
            ground_reg <= SB'(gadj >>> 2);
        end
    end

endmodule

/* src/acsq_fifo.sv */
// Two-entry queue between front and back ends.
module acsq_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  acsq_pkg::acsq_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output acsq_pkg::acsq_item_t head,
    output logic                 empty
);
    import acsq_pkg::*;

    acsq_item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

/* src/acsq_back.sv */
// Back end: phase sequencing, sums, ok counters, averaging divider, results.
module acsq_back #(
    parameter int NUM_ADCS   = acsq_pkg::NUM_ADCS_DEF,
    parameter int COUNT_BITS = acsq_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [acsq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [acsq_pkg::SAMPLE_BITS-1:0]      cfg_data,
    input  logic                                  empty,
    input  acsq_pkg::acsq_item_t                  head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [8+3*acsq_pkg::SAMPLE_BITS-1:0]  m_tdata,
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast
);
    import acsq_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int SW  = SB + CB;
    localparam int AW  = (NUM_ADCS > 1) ? $clog2(NUM_ADCS) : 1;
    localparam int IW  = $clog2(SW);
    localparam int MW  = (CB > REQ_BITS) ? CB : REQ_BITS;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_EXEC  = 3'd1;
    localparam logic [2:0] B_DLOAD = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic signed [SB-1:0]   max_g1_reg, max_g2_reg, full_scale_reg;
    logic [SB-2:0]          max_res_reg;
    logic [REQ_BITS-1:0]    req_rounds_reg;

    logic [2:0]             state_reg;
    logic [1:0]             phase_reg;
    logic [CB-1:0]          cnt_reg [NUM_ADCS];
    logic                   rok_reg;
    logic [CB-1:0]          gr_reg;
    logic signed [SW-1:0]   sum_reg [NUM_ADCS][3];
    acsq_item_t             item_reg;

    logic                   rec_reg;
    logic [1:0]             rgain_reg;
    logic [1:0]             req_reg;
    logic [AW-1:0]          radc_reg;
    logic [1:0]             rf_reg;
    logic [CB-1:0]          n_reg;
    logic [SW-1:0]          dq_reg;
    logic [CB-1:0]          rem_reg;
    logic                   neg_reg;
    logic [IW-1:0]          it_reg;

    logic [1:0]             o_phase_reg, o_gain_reg, o_rgain_reg, o_radc_reg;
    logic                   o_fin_reg, o_rvalid_reg, o_last_reg, o_valid_reg;
    logic signed [SB-1:0]   avg_reg [3];

    logic [AW-1:0]          adc;
    logic                   adc_ok, all_ok, fail;
    logic [CB-1:0]          gr_next;
    logic [CB:0]            trial;
    logic                   take;
    logic [CB-1:0]          rem_next;
    logic [SW-1:0]          dq_next;
    logic signed [SW-1:0]   dsrc;

    assign adc    = item_reg.adc[AW-1:0];
    assign adc_ok = (32'(item_reg.adc) < NUM_ADCS);
    assign pop    = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        all_ok = rok_reg;
        if (item_reg.adc == 2'd0)
        begin
            all_ok = 1'b1;
            for (int i = 0; i < NUM_ADCS; i++)
            begin
                if (cnt_reg[i] == '0)
                begin
                    all_ok = 1'b0;
                end
            end
        end
        if (phase_reg == PHASE_ONE)
        begin
            fail = (item_reg.ground > max_g1_reg) ||
                   (item_reg.res_mag > (SB+2)'(max_res_reg));
        end
        else
        begin
            fail = (item_reg.supply != full_scale_reg) ||
                   (item_reg.ground > max_g2_reg);
        end
        if (all_ok)
        begin
            gr_next = (gr_reg != '1) ? gr_reg + CB'(1) : gr_reg;
        end
        else
        begin
            gr_next = '0;
        end
        trial    = {rem_reg, dq_reg[SW-1]};
        take     = (trial >= {1'b0, n_reg});
        rem_next = take ? CB'(trial - {1'b0, n_reg}) : CB'(trial);
        dq_next  = {dq_reg[SW-2:0], take};
        dsrc     = sum_reg[radc_reg][rf_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_g1_reg     <= '0;
            max_res_reg    <= '0;
            max_g2_reg     <= '0;
            full_scale_reg <= SB'({1'b0, {(SB-1){1'b1}}});
            req_rounds_reg <= REQ_BITS'(300);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_GROUND_ONE:   max_g1_reg     <= cfg_data;
                CFG_MAX_RESIDUAL_ONE: max_res_reg    <= cfg_data[SB-2:0];
                CFG_MAX_GROUND_TWO:   max_g2_reg     <= cfg_data;
                CFG_FULL_SCALE:       full_scale_reg <= cfg_data;
                CFG_REQUIRED_ROUNDS:  req_rounds_reg <= cfg_data[REQ_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            phase_reg   <= PHASE_START;
            rok_reg     <= 1'b0;
            gr_reg      <= '0;
            o_valid_reg <= 1'b0;
            rec_reg     <= 1'b0;
            for (int i = 0; i < NUM_ADCS; i++)
            begin
                cnt_reg[i] <= '0;
                for (int f = 0; f < 3; f++)
                begin
                    sum_reg[i][f] <= '0;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        item_reg  <= head;
                        state_reg <= B_EXEC;
                    end
                end
                B_EXEC:
                begin
                    o_gain_reg   <= GAIN_NONE;
                    o_fin_reg    <= 1'b0;
                    o_rvalid_reg <= 1'b0;
                    o_rgain_reg  <= 2'd0;
                    o_radc_reg   <= 2'd0;
                    o_last_reg   <= 1'b1;
                    o_phase_reg  <= phase_reg;
                    for (int f = 0; f < 3; f++)
                    begin
                        avg_reg[f] <= '0;
                    end
                    rec_reg     <= 1'b0;
                    o_valid_reg <= 1'b1;
                    state_reg   <= B_OUT;
                    if (item_reg.command == CMD_STEP)
                    begin
                        if (phase_reg == PHASE_START)
                        begin
                            rok_reg   <= 1'b0;
                            gr_reg    <= '0;
                            phase_reg <= PHASE_ONE;
                            o_phase_reg <= PHASE_ONE;
                            o_gain_reg  <= GAIN_ONE;
                            for (int i = 0; i < NUM_ADCS; i++)
                            begin
                                cnt_reg[i] <= '0;
                                for (int f = 0; f < 3; f++)
                                begin
                                    sum_reg[i][f] <= '0;
                                end
                            end
                        end
                        else if (phase_reg == PHASE_DONE)
                        begin
                            o_fin_reg <= 1'b1;
                        end
                    end
                    else if ((phase_reg == PHASE_ONE || phase_reg == PHASE_TWO)
                             && adc_ok)
                    begin
                        rok_reg <= all_ok;
                        if (all_ok)
                        begin
                            sum_reg[adc][0] <= sum_reg[adc][0] + SW'(item_reg.ground);
                            sum_reg[adc][1] <= sum_reg[adc][1] + SW'(item_reg.supply);
                            sum_reg[adc][2] <= sum_reg[adc][2] + SW'(item_reg.mid);
                        end
                        else
                        begin
                            for (int f = 0; f < 3; f++)
                            begin
                                sum_reg[adc][f] <= '0;
                            end
                        end
                        if (fail)
                        begin
                            cnt_reg[adc] <= '0;
                        end
                        else if (cnt_reg[adc] != '1)
                        begin
                            cnt_reg[adc] <= cnt_reg[adc] + CB'(1);
                        end
                        if (32'(item_reg.adc) == NUM_ADCS - 1)
                        begin
                            gr_reg <= gr_next;
                            if (MW'(gr_next) > MW'(req_rounds_reg))
                            begin
                                o_valid_reg <= 1'b0;
                                rec_reg     <= 1'b1;
                                rgain_reg   <= phase_reg;
                                n_reg       <= gr_next;
                                radc_reg    <= '0;
                                rf_reg      <= 2'd0;
                                state_reg   <= B_DLOAD;
                                if (phase_reg == PHASE_ONE)
                                begin
                                    phase_reg <= PHASE_TWO;
                                    req_reg   <= GAIN_TWO;
                                end
                                else
                                begin
                                    phase_reg <= PHASE_DONE;
                                    req_reg   <= GAIN_NONE;
                                end
                            end
                        end
                    end
                end
                B_DLOAD:
                begin
                    neg_reg   <= dsrc[SW-1];
                    dq_reg    <= dsrc[SW-1] ? SW'(-dsrc) : SW'(dsrc);
                    rem_reg   <= '0;
                    it_reg    <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    rem_reg <= rem_next;
                    dq_reg  <= dq_next;
                    it_reg  <= it_reg + IW'(1);
                    if (32'(it_reg) == SW - 1)
                    begin
                        avg_reg[rf_reg] <= neg_reg ? -$signed(dq_next[SB-1:0])
                                                   : $signed(dq_next[SB-1:0]);
                        if (rf_reg == 2'd2)
                        begin
                            o_phase_reg  <= phase_reg;
                            o_gain_reg   <= req_reg;
                            o_fin_reg    <= 1'b0;
                            o_rvalid_reg <= 1'b1;
                            o_rgain_reg  <= rgain_reg;
                            o_radc_reg   <= 2'(radc_reg);
                            o_last_reg   <= (32'(radc_reg) == NUM_ADCS - 1);
                            o_valid_reg  <= 1'b1;
                            state_reg    <= B_OUT;
                        end
                        else
                        begin
                            rf_reg    <= rf_reg + 2'd1;
                            state_reg <= B_DLOAD;
                        end
                    end
                end
                B_OUT:
                begin
                    if (m_tready)
                    begin
                        o_valid_reg <= 1'b0;
                        state_reg   <= B_IDLE;
                        if (rec_reg && !o_last_reg)
                        begin
                            radc_reg  <= radc_reg + AW'(1);
                            rf_reg    <= 2'd0;
                            state_reg <= B_DLOAD;
                        end
                        else if (rec_reg && rgain_reg == PHASE_ONE)
                        begin
                            rok_reg <= 1'b0;
                            gr_reg  <= '0;
                            for (int i = 0; i < NUM_ADCS; i++)
                            begin
                                cnt_reg[i] <= '0;
                                for (int f = 0; f < 3; f++)
                                begin
                                    sum_reg[i][f] <= '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_rvalid_reg, o_fin_reg};
    assign m_tdata  = {avg_reg[2], avg_reg[1], avg_reg[0],
                       o_radc_reg, o_rgain_reg, o_gain_reg, o_phase_reg};

endmodule

/* src/adc_two_gain_calibration_sequencer_top.sv */
// Top level of the two-gain ADC calibration sequencer.
//  channel  dir  signals                         contents
//  s        in   s_tvalid s_tready s_tdata/tuser sample or step word
//  m        out  m_tvalid m_tready m_tdata/tuser/tlast  status or record word
//  cfg      in   cfg_we cfg_index cfg_data       threshold registers
// Front forms each word (sum, x1/3 multiply, residual) and takes no new word until it has pushed
// the last into a 2-deep queue; back pops, executes and presents each result in turn.
// A phase-ending round adds NUM_ADCS*3 divisions, each a load step followed by the
// one-bit-per-cycle restoring divider.
// Reset clears all phase, counter and sum state; no clearing pass.
// Back end holds each result until taken; the front keeps filling the queue meanwhile.
module adc_two_gain_calibration_sequencer_top #(
    parameter int NUM_ADCS   = acsq_pkg::NUM_ADCS_DEF,
    parameter int COUNT_BITS = acsq_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // chan_zero .. chan_seven
    input  logic [acsq_pkg::NUM_CHANS*acsq_pkg::SAMPLE_BITS-1:0] s_tdata,
    // command, adc_index
    input  logic [2:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // phase, gain_request, record_gain, record_adc, avg_ground, avg_supply, avg_mid
    output logic [8+3*acsq_pkg::SAMPLE_BITS-1:0]  m_tdata,
    // finished, record_valid
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [acsq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [acsq_pkg::SAMPLE_BITS-1:0]      cfg_data
);
    import acsq_pkg::*;

    logic       push, full, pop, empty;
    acsq_item_t push_item, head;

    acsq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    acsq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    acsq_back #(
        .NUM_ADCS   (NUM_ADCS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* bench/tb_adc_two_gain_calibration_sequencer_top.sv */
// Self-checking testbench for the two-gain ADC calibration sequencer top level.
`timescale 1ns / 100ps

module tb_adc_two_gain_calibration_sequencer_top;
    import acsq_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int NA = 3;
    localparam longint CNT_MAX = 65535;
    localparam longint S_MAX = 8388607;
    localparam longint S_MIN = -8388608;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic [1:0]    phase;
        logic [1:0]    gain;
        logic          fin;
        logic          valid;
        logic [1:0]    rgain;
        logic [1:0]    radc;
        logic [SB-1:0] g;
        logic [SB-1:0] s;
        logic [SB-1:0] mid;
        logic          last;
    } cal_result_t;

    typedef struct packed {
        logic [NUM_CHANS*SB-1:0] data;
        logic [2:0]              user;
    } cal_word_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [NUM_CHANS*SB-1:0]      s_tdata;
    logic [2:0]                   s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [8+3*SB-1:0]            m_tdata;
    logic [1:0]                   m_tuser;
    logic                         m_tlast;
    logic                         cfg_we;
    logic [CFG_IDX_BITS-1:0]      cfg_index;
    logic [SB-1:0]                cfg_data;

    adc_two_gain_calibration_sequencer_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // calibration state mirror
    longint max_gnd_one, max_res_one, max_gnd_two, full_scale, req_rounds;
    logic [1:0] cal_phase;
    longint ok_count [NA];
    bit     round_ok;
    longint good_cnt;
    longint sum_gnd [NA];
    longint sum_sup [NA];
    longint sum_mid [NA];

    cal_word_t   pending_words[$];
    cal_result_t expected_results[$];

    int words_sent, results_checked, records_seen, mismatches;
    int burst_left, gap_left, pat_left, pat_mode, stall_cnt;
    bit stall_req, stall_done;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic clear_run();
        for (int i = 0; i < NA; i++)
        begin
            ok_count[i] = 0;
            sum_gnd[i] = 0;
            sum_sup[i] = 0;
            sum_mid[i] = 0;
        end
        good_cnt = 0;
        round_ok = 1'b0;
    endtask

    task automatic push_status(input logic [1:0] gain, input logic fin);
        cal_result_t r;
        r = '0;
        r.phase = cal_phase;
        r.gain = gain;
        r.fin = fin;
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic predict_calibration(input cal_word_t w);
        longint ch [8];
        longint m, p, l, r, mag;
        logic [1:0] adc, req, gphase;
        bit fail;
        cal_result_t rec [NA];
        adc = w.user[2:1];
        if (w.user[0] == CMD_STEP)
        begin
            if (cal_phase == PHASE_START)
            begin
                clear_run();
                cal_phase = PHASE_ONE;
                push_status(GAIN_ONE, 1'b0);
            end
            else
                push_status(GAIN_NONE, cal_phase == PHASE_DONE);
            return;
        end
        if ((cal_phase != PHASE_ONE && cal_phase != PHASE_TWO) || adc >= NA)
        begin
            push_status(GAIN_NONE, 1'b0);
            return;
        end
        for (int i = 0; i < 8; i++)
            ch[i] = $signed(w.data[i*SB +: SB]);
        m = (ch[1] + ch[3] + ch[5] + ch[7]) / 4;
        p = (ch[0] + ch[2] + ch[6]) / 3;
        l = ch[4];
        r = (p - m) / 2 - (l - m);
        if (adc == 0)
        begin
            round_ok = 1'b1;
            for (int i = 0; i < NA; i++)
                if (ok_count[i] == 0)
                    round_ok = 1'b0;
        end
        if (round_ok)
        begin
            sum_gnd[adc] += m;
            sum_sup[adc] += p;
            sum_mid[adc] += l;
        end
        else
        begin
            sum_gnd[adc] = 0;
            sum_sup[adc] = 0;
            sum_mid[adc] = 0;
        end
        if (cal_phase == PHASE_ONE)
        begin
            mag = (r < 0) ? -r : r;
            fail = (m > max_gnd_one) || (mag > max_res_one);
        end
        else
            fail = (p != full_scale) || (m > max_gnd_two);
        if (fail)
            ok_count[adc] = 0;
        else if (ok_count[adc] < CNT_MAX)
            ok_count[adc]++;
        if (adc != NA - 1)
        begin
            push_status(GAIN_NONE, 1'b0);
            return;
        end
        if (round_ok)
        begin
            if (good_cnt < CNT_MAX)
                good_cnt++;
        end
        else
            good_cnt = 0;
        if (good_cnt <= req_rounds)
        begin
            push_status(GAIN_NONE, 1'b0);
            return;
        end
        gphase = cal_phase;
        for (int i = 0; i < NA; i++)
        begin
            rec[i] = '0;
            rec[i].valid = 1'b1;
            rec[i].rgain = gphase;
            rec[i].radc = i[1:0];
            rec[i].g = SB'(sum_gnd[i] / good_cnt);
            rec[i].s = SB'(sum_sup[i] / good_cnt);
            rec[i].mid = SB'(sum_mid[i] / good_cnt);
            rec[i].last = (i == NA - 1);
        end
        if (cal_phase == PHASE_ONE)
        begin
            clear_run();
            cal_phase = PHASE_TWO;
            req = GAIN_TWO;
        end
        else
        begin
            cal_phase = PHASE_DONE;
            req = GAIN_NONE;
        end
        for (int i = 0; i < NA; i++)
        begin
            rec[i].phase = cal_phase;
            rec[i].gain = req;
            expected_results.push_back(rec[i]);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 4;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_calibration(pending_words.pop_front());
                words_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                           : $urandom_range(0, 4);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_words[0].data;
                s_tuser <= pending_words[0].user;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            pat_left = 0;
            pat_mode = 0;
            stall_cnt = 0;
            stall_done = 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            if (stall_cnt == 0)
                stall_done = 1'b1;
            m_tready <= 1'b0;
        end
        else if (stall_req && !stall_done)
        begin
            stall_cnt = 400;
            m_tready <= 1'b0;
        end
        else
        begin
            if (pat_left <= 0)
            begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(5, 60);
            end
            pat_left--;
            case (pat_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cal_result_t act, exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.phase = m_tdata[1:0];
            act.gain = m_tdata[3:2];
            act.rgain = m_tdata[5:4];
            act.radc = m_tdata[7:6];
            act.g = m_tdata[8 +: SB];
            act.s = m_tdata[8+SB +: SB];
            act.mid = m_tdata[8+2*SB +: SB];
            act.fin = m_tuser[0];
            act.valid = m_tuser[1];
            act.last = m_tlast;
            results_checked++;
            if (act.valid)
                records_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", act);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp ph%0d gn%0d fin%0d v%0d rg%0d ra%0d g%h s%h m%h l%0d",
                                 exp_r.phase, exp_r.gain, exp_r.fin, exp_r.valid,
                                 exp_r.rgain, exp_r.radc, exp_r.g, exp_r.s, exp_r.mid,
                                 exp_r.last);
                        $display("          act ph%0d gn%0d fin%0d v%0d rg%0d ra%0d g%h s%h m%h l%0d",
                                 act.phase, act.gain, act.fin, act.valid,
                                 act.rgain, act.radc, act.g, act.s, act.mid, act.last);
                    end
                end
            end
        end
    end

    task automatic settle();
        while (pending_words.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input longint val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= SB'(val);
        case (idx)
            CFG_MAX_GROUND_ONE:   max_gnd_one = val;
            CFG_MAX_RESIDUAL_ONE: max_res_one = val;
            CFG_MAX_GROUND_TWO:   max_gnd_two = val;
            CFG_FULL_SCALE:       full_scale = val;
            CFG_REQUIRED_ROUNDS:  req_rounds = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_word(input logic cmd, input logic [1:0] adc,
                            input logic [NUM_CHANS*SB-1:0] d);
        cal_word_t w;
        w.data = d;
        w.user = {adc, cmd};
        pending_words.push_back(w);
    endtask

    function automatic logic [SB-1:0] rand_chan(input bit narrow);
        if (narrow)
            return SB'(longint'($urandom_range(0, 2097151)) - 1048576);
        return SB'($urandom);
    endfunction

    // narrow: small codes; fix_sup: supply channels equal sup; gnd_min: ground at minimum
    task automatic add_sample(input logic [1:0] adc, input bit narrow, input bit fix_sup,
                              input longint sup, input bit gnd_min);
        logic [NUM_CHANS*SB-1:0] d;
        for (int i = 0; i < 8; i++)
            d[i*SB +: SB] = rand_chan(narrow);
        if (fix_sup)
        begin
            d[0*SB +: SB] = SB'(sup);
            d[2*SB +: SB] = SB'(sup);
            d[6*SB +: SB] = SB'(sup);
        end
        if (gnd_min)
            for (int i = 1; i < 8; i += 2)
                d[i*SB +: SB] = SB'(S_MIN);
        add_word(CMD_SAMPLE, adc, d);
    endtask

    task automatic add_round(input bit narrow, input bit fix_sup, input longint sup,
                             input bit gnd_min);
        for (int a = 0; a < NA; a++)
            add_sample(a[1:0], narrow, fix_sup, sup, gnd_min);
    endtask

    task automatic add_batch(input int rounds, input int good_pct, input bit two,
                             input longint sup, input bit gnd_min);
        int r;
        bit good;
        for (int k = 0; k < rounds; k++)
        begin
            r = $urandom_range(0, 99);
            good = ($urandom_range(0, 99) < good_pct);
            if (r < 8)
                add_sample(2'($urandom_range(0, 3)), 1'b0, 1'b0, 0, 1'b0);
            else if (r < 12)
                add_word(CMD_STEP, 2'($urandom_range(0, 3)), {8{rand_chan(1'b0)}});
            else if (r < 16)
                add_sample(2'($urandom_range(1, 2)), good, two && good, sup,
                           gnd_min && good);
            else
                add_round(good, two && good, sup, gnd_min && good);
        end
    endtask

    initial begin
        longint fs_rand;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_req = 1'b0;
        words_sent = 0;
        results_checked = 0;
        records_seen = 0;
        mismatches = 0;
        max_gnd_one = 0;
        max_res_one = 0;
        max_gnd_two = 0;
        full_scale = S_MAX;
        req_rounds = 300;
        cal_phase = PHASE_START;
        clear_run();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: start phase, bad index, extremes, zero round under reset thresholds
        add_sample(2'd0, 1'b0, 1'b0, 0, 1'b0);
        add_word(CMD_STEP, 2'd0, '0);
        add_sample(2'd3, 1'b0, 1'b0, 0, 1'b0);
        add_word(CMD_STEP, 2'd1, '1);
        add_word(CMD_SAMPLE, 2'd0, {8{SB'(S_MAX)}});
        add_word(CMD_SAMPLE, 2'd1, {8{SB'(S_MIN)}});
        add_word(CMD_SAMPLE, 2'd2, {4{SB'(S_MIN), SB'(S_MAX)}});
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < NA; a++)
                add_word(CMD_SAMPLE, a[1:0], '0);
        settle();

        write_reg(CFG_MAX_GROUND_ONE, S_MIN);
        write_reg(CFG_MAX_RESIDUAL_ONE, 0);
        write_reg(CFG_REQUIRED_ROUNDS, 65534);
        add_batch(8, 50, 1'b0, 0, 1'b0);
        settle();

        write_reg(CFG_MAX_GROUND_ONE, S_MAX);
        write_reg(CFG_MAX_RESIDUAL_ONE, S_MAX);
        stall_req = 1'b1;
        add_batch(30, 85, 1'b0, 0, 1'b0);
        settle();

        // end of gain one
        write_reg(CFG_REQUIRED_ROUNDS, 0);
        add_round(1'b1, 1'b0, 0, 1'b0);
        add_round(1'b1, 1'b0, 0, 1'b0);
        settle();

        write_reg(CFG_MAX_GROUND_TWO, S_MAX);
        write_reg(CFG_FULL_SCALE, S_MIN);
        write_reg(CFG_REQUIRED_ROUNDS, 65534);
        add_batch(12, 70, 1'b1, S_MIN, 1'b0);
        settle();

        fs_rand = longint'($urandom_range(0, 16777215)) - 8388608;
        write_reg(CFG_MAX_GROUND_TWO, S_MIN);
        write_reg(CFG_FULL_SCALE, fs_rand);
        write_reg(CFG_REQUIRED_ROUNDS, 2);
        for (int k = 0; k < 6; k++)
            add_round(1'b1, 1'b1, fs_rand, 1'b1);
        add_word(CMD_STEP, 2'd0, '0);
        add_sample(2'd0, 1'b1, 1'b0, 0, 1'b0);
        add_word(CMD_STEP, 2'd2, '0);
        settle();

        $display("sent %0d words through both gain phases, checked %0d results", words_sent,
                 results_checked);
        $display("%0d calibration records, %0d mismatches", records_seen, mismatches);
        if (mismatches == 0)
            $display("tb_adc_two_gain_calibration_sequencer_top: PASS");
        else
            $display("tb_adc_two_gain_calibration_sequencer_top: FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_adc_two_gain_calibration_sequencer_top: FAIL");
        $finish;
    end

endmodule
